// ===== rtl/stu_pkg.sv =====
package stu_pkg;

  // Default counter widths
  localparam int LINE_BITS_DEF   = 16;
  localparam int COL_BITS_DEF    = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = 2;
  localparam int CNT_BITS   = 3;

  localparam logic [4:0] TAB_RESET = 5'd8;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  // Byte codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ULINE = 8'h5F;

  // Keywords packed big-endian, last byte in the low bits
  localparam logic [47:0] KW_FN     = 48'h0000_0000_666E;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
  localparam logic [47:0] KW_TRUE   = 48'h0000_7472_7565;
  localparam logic [47:0] KW_FALSE  = 48'h0066_616C_7365;

  typedef enum logic [4:0] {
    KIND_INT    = 5'd0,
    KIND_BOOL   = 5'd1,
    KIND_IDENT  = 5'd2,
    KIND_FN     = 5'd3,
    KIND_RETURN = 5'd4,
    KIND_GE     = 5'd5,
    KIND_LE     = 5'd6,
    KIND_EQ     = 5'd7,
    KIND_NE     = 5'd8,
    KIND_GT     = 5'd9,
    KIND_LT     = 5'd10,
    KIND_MUL    = 5'd11,
    KIND_ADD    = 5'd12,
    KIND_ASSIGN = 5'd13,
    KIND_SEMI   = 5'd14,
    KIND_LPAREN = 5'd15,
    KIND_RPAREN = 5'd16,
    KIND_LBRACE = 5'd17,
    KIND_RBRACE = 5'd18,
    KIND_COMMA  = 5'd19,
    KIND_COLON  = 5'd20,
    KIND_ERROR  = 5'd21
  } kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUM     = 5'b00010,
    MODE_WORD    = 5'b00100,
    MODE_OP      = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  first_line;
    logic [15:0]  first_col;
    logic [15:0]  stop_line;
    logic [15:0]  end_col;
    logic [30:0]  int_value;
    logic         bool_value;
    logic [31:0]  ident_offset;
    logic [15:0]  ident_length;
    logic         overflow;
    logic         last;
  } token_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_ULINE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_op_start(logic [7:0] c);
    return (c == CH_GT) || (c == CH_LT) || (c == CH_EQ) || (c == CH_BANG) ||
           (c == CH_SLASH);
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      8'h3E:   k = KIND_GT;
      8'h3C:   k = KIND_LT;
      8'h2A:   k = KIND_MUL;
      8'h2B:   k = KIND_ADD;
      8'h3D:   k = KIND_ASSIGN;
      8'h3B:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h3A:   k = KIND_COLON;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/source_tokenizer_unit.sv =====
// Source tokenizer: one source byte per input word, tokens out.
//
// Input channel (in_valid / in_stall): in_byte plus end_of_input. A word with
// end_of_input set consumes no byte; it flushes the open token, if any.
// Output channel (out_valid / out_stall): one token per word, fields on their
// own ports; last marks the final token caused by an input word.
// Config channel (cfg_valid / cfg_ready / cfg_data): tab_advance. cfg_ready is
// always high. User must write it only while the block is idle, unenforced.
//
// Tokens are registered into the output queue as their input word is taken.
// Throughput: one input word per cycle while in_stall is low. A word may
// close the open token and also emit one for its own byte; the second token
// leaves after the first. Tokens wait in a four-word output queue, so input
// keeps flowing while the receiver stalls; in_stall rises once more than two
// words are queued (room for the worst-case pair must be free).
//
// Reset (rst, synchronous): line and column back to 1, byte offset 0,
// scanner idle, queue empty, tab_advance 8.
module source_tokenizer_unit #(
  parameter int LINE_BITS   = stu_pkg::LINE_BITS_DEF,
  parameter int COL_BITS    = stu_pkg::COL_BITS_DEF,
  parameter int OFFSET_BITS = stu_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  // tokens
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] first_line,
  output logic [15:0] first_col,
  output logic [15:0] stop_line,
  output logic [15:0] end_col,
  output logic [30:0] int_value,
  output logic        bool_value,
  output logic [31:0] ident_offset,
  output logic [15:0] ident_length,
  output logic        overflow,
  output logic        last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  function automatic logic [15:0] line16(logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+15:0] e;
    e = {16'd0, v};
    return e[15:0];
  endfunction

  function automatic logic [15:0] col16(logic [COL_BITS-1:0] v);
    logic [COL_BITS+15:0] e;
    e = {16'd0, v};
    return e[15:0];
  endfunction

  function automatic logic [31:0] off32(logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+31:0] e;
    e = {32'd0, v};
    return e[31:0];
  endfunction

  // ---------------------------------------------------------------- state
  logic [4:0]             tab_advance;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [COL_BITS-1:0]    column_count, column_count_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  stu_pkg::mode_t         mode, mode_next;
  logic [7:0]             pending_char, pending_char_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COL_BITS-1:0]    tok_col, tok_col_next;
  logic [OFFSET_BITS-1:0] tok_offset, tok_offset_next;
  logic [30:0]            number_accum, number_accum_next;
  logic                   number_ovf, number_ovf_next;
  logic [15:0]            word_length, word_length_next;
  logic [47:0]            keyword_window, keyword_window_next;

  // output queue
  stu_pkg::token_t               fifo [stu_pkg::FIFO_DEPTH];
  logic [stu_pkg::PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [stu_pkg::CNT_BITS-1:0]  count;

  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > stu_pkg::CNT_BITS'(2));
  assign out_valid = (count != '0);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  // ------------------------------------------------- position after a byte
  logic [LINE_BITS-1:0]   line_adv;
  logic [COL_BITS-1:0]    col_adv;
  logic [OFFSET_BITS-1:0] off_adv;
  logic [COL_BITS:0]      col_tab_sum;

  always_comb begin
    col_tab_sum = {1'b0, column_count} + {{(COL_BITS-4){1'b0}}, tab_advance};
    off_adv     = byte_offset + OFFSET_BITS'(1);
    line_adv    = line_count;
    if (in_byte == stu_pkg::CH_LF) begin
      line_adv = (&line_count) ? line_count : line_count + LINE_BITS'(1);
      col_adv  = COL_BITS'(1);
    end else if (in_byte == stu_pkg::CH_TAB) begin
      col_adv = col_tab_sum[COL_BITS] ? '1 : col_tab_sum[COL_BITS-1:0];
    end else begin
      col_adv = (&column_count) ? column_count : column_count + COL_BITS'(1);
    end
  end

  // --------------------------------------- token closing the open literal
  stu_pkg::token_t close_tok;
  logic            close_has;

  always_comb begin
    close_tok            = '0;
    close_tok.first_line = line16(tok_line);
    close_tok.first_col  = col16(tok_col);
    close_tok.stop_line  = line16(line_count);
    close_tok.end_col    = col16(column_count);
    close_has            = 1'b1;
    case (mode)
      stu_pkg::MODE_NUM: begin
        close_tok.kind      = stu_pkg::KIND_INT;
        close_tok.int_value = number_accum;
        close_tok.overflow  = number_ovf;
      end
      stu_pkg::MODE_WORD: begin
        if (word_length == 16'd2 && keyword_window == stu_pkg::KW_FN) begin
          close_tok.kind = stu_pkg::KIND_FN;
        end else if (word_length == 16'd6 && keyword_window == stu_pkg::KW_RETURN) begin
          close_tok.kind = stu_pkg::KIND_RETURN;
        end else if (word_length == 16'd4 && keyword_window == stu_pkg::KW_TRUE) begin
          close_tok.kind       = stu_pkg::KIND_BOOL;
          close_tok.bool_value = 1'b1;
        end else if (word_length == 16'd5 && keyword_window == stu_pkg::KW_FALSE) begin
          close_tok.kind = stu_pkg::KIND_BOOL;
        end else begin
          close_tok.kind         = stu_pkg::KIND_IDENT;
          close_tok.ident_offset = off32(tok_offset);
          close_tok.ident_length = word_length;
        end
      end
      stu_pkg::MODE_OP: begin
        // lone ! or / falls out as an error token here
        close_tok.kind = stu_pkg::single_kind(pending_char);
      end
      default: begin
        close_has = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------- main scanner
  logic [34:0]     accum_mul;
  stu_pkg::token_t tok_a, tok_b, idle_tok, cmp_tok;
  logic [1:0]      tok_count;
  logic            run_idle, do_consume;

  always_comb begin
    accum_mul = ({4'd0, number_accum} << 3) + ({4'd0, number_accum} << 1) +
                {31'd0, in_byte[3:0]};

    idle_tok            = '0;
    idle_tok.kind       = stu_pkg::single_kind(in_byte);
    idle_tok.first_line = line16(line_count);
    idle_tok.first_col  = col16(column_count);
    idle_tok.stop_line  = line16(line_adv);
    idle_tok.end_col    = col16(col_adv);

    cmp_tok            = '0;
    cmp_tok.first_line = line16(tok_line);
    cmp_tok.first_col  = col16(tok_col);
    cmp_tok.stop_line  = line16(line_adv);
    cmp_tok.end_col    = col16(col_adv);
    if (pending_char == stu_pkg::CH_GT) begin
      cmp_tok.kind = stu_pkg::KIND_GE;
    end else if (pending_char == stu_pkg::CH_LT) begin
      cmp_tok.kind = stu_pkg::KIND_LE;
    end else if (pending_char == stu_pkg::CH_EQ) begin
      cmp_tok.kind = stu_pkg::KIND_EQ;
    end else begin
      cmp_tok.kind = stu_pkg::KIND_NE;
    end

    mode_next           = mode;
    pending_char_next   = pending_char;
    tok_line_next       = tok_line;
    tok_col_next        = tok_col;
    tok_offset_next     = tok_offset;
    number_accum_next   = number_accum;
    number_ovf_next     = number_ovf;
    word_length_next    = word_length;
    keyword_window_next = keyword_window;
    tok_a               = '0;
    tok_b               = '0;
    tok_count           = 2'd0;
    run_idle            = 1'b0;
    do_consume          = 1'b0;

    if (end_of_input) begin
      if (close_has) begin
        tok_a     = close_tok;
        tok_count = 2'd1;
      end
      if (mode == stu_pkg::MODE_OP) begin
        pending_char_next = '0;
      end
      mode_next = stu_pkg::MODE_IDLE;
    end else begin
      case (mode)
        stu_pkg::MODE_NUM: begin
          if (stu_pkg::is_digit(in_byte)) begin
            do_consume = 1'b1;
            if (!number_ovf) begin
              if (accum_mul > {4'd0, stu_pkg::INT_MAX31}) begin
                number_accum_next = stu_pkg::INT_MAX31;
                number_ovf_next   = 1'b1;
              end else begin
                number_accum_next = accum_mul[30:0];
              end
            end
          end else begin
            run_idle = 1'b1;
          end
        end
        stu_pkg::MODE_WORD: begin
          if (stu_pkg::is_alpha(in_byte) || stu_pkg::is_digit(in_byte)) begin
            do_consume          = 1'b1;
            word_length_next    = (&word_length) ? word_length : word_length + 16'd1;
            keyword_window_next = {keyword_window[39:0], in_byte};
          end else begin
            run_idle = 1'b1;
          end
        end
        stu_pkg::MODE_OP: begin
          if (in_byte == stu_pkg::CH_SLASH && pending_char == stu_pkg::CH_SLASH) begin
            do_consume        = 1'b1;
            mode_next         = stu_pkg::MODE_COMMENT;
            pending_char_next = '0;
          end else if (in_byte == stu_pkg::CH_EQ && pending_char != stu_pkg::CH_SLASH) begin
            do_consume        = 1'b1;
            tok_a             = cmp_tok;
            tok_count         = 2'd1;
            mode_next         = stu_pkg::MODE_IDLE;
            pending_char_next = '0;
          end else begin
            run_idle = 1'b1;
          end
        end
        stu_pkg::MODE_COMMENT: begin
          do_consume = 1'b1;
          if (in_byte == stu_pkg::CH_LF) begin
            mode_next = stu_pkg::MODE_IDLE;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        // close whatever is open; close never moves the position
        if (close_has) begin
          tok_a     = close_tok;
          tok_count = 2'd1;
        end
        if (mode == stu_pkg::MODE_OP) begin
          pending_char_next = '0;
        end
        mode_next  = stu_pkg::MODE_IDLE;
        do_consume = 1'b1;
        if (stu_pkg::is_space(in_byte)) begin
          mode_next = stu_pkg::MODE_IDLE;
        end else if (stu_pkg::is_digit(in_byte)) begin
          mode_next         = stu_pkg::MODE_NUM;
          number_accum_next = {27'd0, in_byte[3:0]};
          number_ovf_next   = 1'b0;
        end else if (stu_pkg::is_alpha(in_byte)) begin
          mode_next           = stu_pkg::MODE_WORD;
          word_length_next    = 16'd1;
          keyword_window_next = {40'd0, in_byte};
        end else if (stu_pkg::is_op_start(in_byte)) begin
          mode_next         = stu_pkg::MODE_OP;
          pending_char_next = in_byte;
        end else begin
          if (close_has) begin
            tok_b     = idle_tok;
            tok_count = 2'd2;
          end else begin
            tok_a     = idle_tok;
            tok_count = 2'd1;
          end
        end
        if (!stu_pkg::is_space(in_byte)) begin
          tok_line_next   = line_count;
          tok_col_next    = column_count;
          tok_offset_next = byte_offset;
        end
      end
    end

    if (tok_count == 2'd2) begin
      tok_b.last = 1'b1;
    end else begin
      tok_a.last = 1'b1;
    end

    line_count_next   = do_consume ? line_adv : line_count;
    column_count_next = do_consume ? col_adv  : column_count;
    byte_offset_next  = do_consume ? off_adv  : byte_offset;
  end

  // -------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_advance  <= stu_pkg::TAB_RESET;
      line_count   <= LINE_BITS'(1);
      column_count <= COL_BITS'(1);
      byte_offset  <= '0;
      mode         <= stu_pkg::MODE_IDLE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tab_advance <= cfg_data;
      end
      if (in_fire) begin
        line_count   <= line_count_next;
        column_count <= column_count_next;
        byte_offset  <= byte_offset_next;
        mode         <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pending_char   <= pending_char_next;
      tok_line       <= tok_line_next;
      tok_col        <= tok_col_next;
      tok_offset     <= tok_offset_next;
      number_accum   <= number_accum_next;
      number_ovf     <= number_ovf_next;
      word_length    <= word_length_next;
      keyword_window <= keyword_window_next;
    end
  end

  // ------------------------------------------------------ output queue
  logic [stu_pkg::PTR_BITS-1:0] wr_ptr_b;
  logic [stu_pkg::CNT_BITS-1:0] push_n;

  assign wr_ptr_b = wr_ptr + stu_pkg::PTR_BITS'(1);
  assign push_n   = in_fire ? {1'b0, tok_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[stu_pkg::PTR_BITS-1:0];
      if (out_fire) begin
        rd_ptr <= rd_ptr + stu_pkg::PTR_BITS'(1);
      end
      count <= count + push_n - {{(stu_pkg::CNT_BITS-1){1'b0}}, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && tok_count != 2'd0) begin
      fifo[wr_ptr] <= tok_a;
    end
    if (in_fire && tok_count == 2'd2) begin
      fifo[wr_ptr_b] <= tok_b;
    end
  end

  stu_pkg::token_t head;
  assign head = fifo[rd_ptr];

  assign token_kind   = head.kind;
  assign first_line   = head.first_line;
  assign first_col    = head.first_col;
  assign stop_line    = head.stop_line;
  assign end_col      = head.end_col;
  assign int_value    = head.int_value;
  assign bool_value   = head.bool_value;
  assign ident_offset = head.ident_offset;
  assign ident_length = head.ident_length;
  assign overflow     = head.overflow;
  assign last         = head.last;

`ifndef SYNTHESIS
  // queue never holds more words than it has slots
  assert property (@(posedge clk) disable iff (rst)
    count <= stu_pkg::CNT_BITS'(stu_pkg::FIFO_DEPTH))
    else $error("token queue overflow");

  // a flush always leaves the scanner idle
  assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_input |=> mode == stu_pkg::MODE_IDLE)
    else $error("scanner not idle after flush");

  // inside a comment only a newline or a flush ends it
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !end_of_input && mode == stu_pkg::MODE_COMMENT &&
    in_byte != stu_pkg::CH_LF |=> mode == stu_pkg::MODE_COMMENT)
    else $error("comment ended early");

  // an overflowed literal holds the saturated value
  assert property (@(posedge clk) disable iff (rst)
    mode == stu_pkg::MODE_NUM && number_ovf |-> number_accum == stu_pkg::INT_MAX31)
    else $error("overflowed literal not saturated");
`endif

endmodule
